// ===== rtl/scba_pkg.sv =====
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and codes of the size-class block allocator: field widths,
// operation and status codes, and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package scba_pkg;

	localparam int REQ_W      = 32;
	localparam int OFFSET_W   = 20;
	localparam int STATUS_W   = 2;
	localparam int CLASS_W    = 3;
	localparam int LARGE_BLOCK_BYTES = 8192;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd3;

	typedef enum logic [2:0] {
		ALC_CLEAR,
		ALC_IDLE,
		ALC_POP,
		ALC_DIV,
		ALC_PUSH,
		ALC_REPLY
	} alc_state_t;

endpackage

`default_nettype wire

// ===== rtl/size_class_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// size_class_block_allocator_core
// Segregated free-list allocator. Each size class keeps a LIFO free list as
// a head register plus entries of one shared link memory (one read port,
// one write port, registered read data).
//
// Input channel (in_valid/in_ready): mode selects allocate or free;
// request_bytes is used on allocate, free_offset on free. One transaction in
// gives exactly one transaction out on the result channel (out_valid/
// out_ready) carrying ok, status, block_offset and size_class.
// Allocate: the head is read at accept, its link arrives from the memory in the
// next cycle and the result is registered.
// Free: the offset is decoded at accept, the block index is formed by a
// reciprocal multiply in the next cycle, and the alignment check follows in the
// push state, which pushes the block only if aligned; decode rejects skip both.
// One item is in flight at a time; in_ready is high whenever no item is in
// flight, also while a result waits in the output register.
// Reset: the heads load at once; then the link memory is swept one entry per
// cycle, all (NUM_CLASSES-1)*BLOCKS_PER_CLASS+LARGE_BLOCKS entries (4128 by
// default), with in_ready low. A stalled receiver holds the finishing item
// and its list update until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_block_allocator_core #(
	parameter int BLOCKS_PER_CLASS     = 1024,
	parameter int LARGE_BLOCKS         = 32,
	parameter int NUM_CLASSES          = 5,
	parameter int SMALLEST_BLOCK_BYTES = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          mode,
	input  wire logic [scba_pkg::REQ_W-1:0]    request_bytes,
	input  wire logic [scba_pkg::OFFSET_W-1:0] free_offset,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               ok,
	output logic [scba_pkg::STATUS_W-1:0]      status,
	output logic [scba_pkg::OFFSET_W-1:0]      block_offset,
	output logic [scba_pkg::CLASS_W-1:0]       size_class
);
	import scba_pkg::*;

	typedef logic [63:0] tab_t [NUM_CLASSES];

	function automatic tab_t bytes_tab();
		tab_t r;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (c == NUM_CLASSES - 1)
				r[c] = 64'(LARGE_BLOCK_BYTES);
			else
				r[c] = 64'(SMALLEST_BLOCK_BYTES) << c;
		end
		return r;
	endfunction

	function automatic tab_t count_tab();
		tab_t r;
		for (int c = 0; c < NUM_CLASSES; c++)
			r[c] = (c == NUM_CLASSES - 1) ? 64'(LARGE_BLOCKS) : 64'(BLOCKS_PER_CLASS);
		return r;
	endfunction

	function automatic tab_t base_tab();
		tab_t r;
		tab_t b;
		tab_t n;
		logic [63:0] acc;
		b = bytes_tab();
		n = count_tab();
		acc = 64'd0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			r[c] = acc;
			acc = acc + b[c] * n[c];
		end
		return r;
	endfunction

	function automatic tab_t shift_tab();
		tab_t r;
		tab_t b;
		b = bytes_tab();
		for (int c = 0; c < NUM_CLASSES; c++)
			r[c] = 64'(OFFSET_W + $clog2(b[c]));
		return r;
	endfunction

	// ceil(2^shift / bytes) by restoring long division
	function automatic tab_t rcp_tab();
		tab_t r;
		tab_t b;
		tab_t s;
		logic [63:0] rem;
		logic [63:0] quo;
		b = bytes_tab();
		s = shift_tab();
		for (int c = 0; c < NUM_CLASSES; c++) begin
			rem = 64'd0;
			quo = 64'd0;
			for (int i = 63; i >= 0; i--) begin
				rem = {rem[62:0], (64'(i) == s[c])};
				quo = {quo[62:0], 1'b0};
				if (rem >= b[c]) begin
					rem = rem - b[c];
					quo[0] = 1'b1;
				end
			end
			r[c] = (rem != 64'd0) ? quo + 64'd1 : quo;
		end
		return r;
	endfunction

	function automatic logic [63:0] max_bytes();
		tab_t b;
		logic [63:0] m;
		b = bytes_tab();
		m = 64'd0;
		for (int c = 0; c < NUM_CLASSES; c++)
			if (b[c] > m)
				m = b[c];
		return m;
	endfunction

	localparam tab_t BYTES_TAB = bytes_tab();
	localparam tab_t COUNT_TAB = count_tab();
	localparam tab_t BASE_TAB  = base_tab();
	localparam tab_t SHIFT_TAB = shift_tab();
	localparam tab_t RCP_TAB   = rcp_tab();

	localparam int MAX_COUNT = (BLOCKS_PER_CLASS > LARGE_BLOCKS) ? BLOCKS_PER_CLASS
		: LARGE_BLOCKS;
	localparam int TOTAL_BLOCKS = (NUM_CLASSES - 1) * BLOCKS_PER_CLASS + LARGE_BLOCKS;
	localparam int LINK_W  = $clog2(MAX_COUNT + 1);
	localparam int LOCAL_W = $clog2(MAX_COUNT);
	localparam int ADDR_W  = $clog2(TOTAL_BLOCKS);
	localparam int CLS_W   = $clog2(NUM_CLASSES);
	localparam int BS_W    = $clog2(max_bytes() + 64'd1);
	localparam int RCP_W   = OFFSET_W + 2;
	localparam int PROD_W  = OFFSET_W + RCP_W;
	localparam int SH_W    = $clog2(PROD_W);
	localparam int CHK_W   = LOCAL_W + BS_W;
	localparam int CMP_W   = (CHK_W > OFFSET_W) ? CHK_W : OFFSET_W;

	alc_state_t state_q, state_d;

	logic [LINK_W-1:0] list_head_q [NUM_CLASSES];
	logic [LINK_W-1:0] link_mem [TOTAL_BLOCKS];
	logic [LINK_W-1:0] link_rd_q;

	logic [ADDR_W-1:0]  clr_addr_q;
	logic [CLS_W-1:0]   clr_cls_q;
	logic [LOCAL_W-1:0] clr_local_q;
	logic               clr_last_local;
	logic               clr_done;

	logic [CLS_W-1:0]    cls_s1;
	logic [LOCAL_W-1:0]  local_s1;
	logic [OFFSET_W-1:0] rel_s1;
	logic [STATUS_W-1:0] status_s1;

	logic                out_valid_q;
	logic                ok_q;
	logic [STATUS_W-1:0] status_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [CLASS_W-1:0]  class_q;

	logic accept;
	logic out_free;

	logic               alloc_fit;
	logic [CLS_W-1:0]   alloc_cls;
	logic [LINK_W-1:0]  head_sel;
	logic [63:0]        acnt_sel;
	logic [63:0]        afirst_sel;
	logic               head_ok;
	logic [ADDR_W-1:0]  alloc_addr;

	logic                free_hit;
	logic [CLS_W-1:0]    free_cls;
	logic [OFFSET_W-1:0] free_rel;

	logic [63:0]         bs_s1;
	logic [63:0]         base_s1;
	logic [63:0]         cnt_s1;
	logic [63:0]         first_s1;
	logic [63:0]         rcp_s1;
	logic [63:0]         sh_s1;
	logic [63:0]         clr_cnt;
	logic [PROD_W-1:0]   rcp_prod;
	logic [LOCAL_W-1:0]  div_local;
	logic [CHK_W-1:0]    chk_prod;
	logic                aligned;
	logic [ADDR_W-1:0]   s1_addr;
	logic [LINK_W-1:0]   pop_head;
	logic [OFFSET_W-1:0] pop_offset;

	logic                ld_s1;
	logic                ld_div;
	logic                ld_out;
	logic                mem_re;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [LINK_W-1:0]   mem_wdata;
	logic                head_we;
	logic [LINK_W-1:0]   head_wdata;
	logic                nx_ok;
	logic [STATUS_W-1:0] nx_status;
	logic [OFFSET_W-1:0] nx_offset;
	logic [CLASS_W-1:0]  nx_class;
	logic [CLS_W-1:0]    nx_cls_s1;
	logic [STATUS_W-1:0] nx_status_s1;

	assign in_ready     = (state_q == ALC_IDLE);
	assign accept       = in_valid & in_ready;
	assign out_free     = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign ok           = ok_q;
	assign status       = status_q;
	assign block_offset = offset_q;
	assign size_class   = class_q;

	// request decode
	always_comb begin
		alloc_fit  = 1'b0;
		alloc_cls  = '0;
		free_hit   = 1'b0;
		free_cls   = '0;
		free_rel   = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (BYTES_TAB[c] >= 64'(request_bytes)) begin
				alloc_fit = 1'b1;
				alloc_cls = CLS_W'(c);
			end
		end
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (64'(free_offset) >= BASE_TAB[c]
				&& 64'(free_offset) < BASE_TAB[c] + BYTES_TAB[c] * COUNT_TAB[c]) begin
				free_hit = 1'b1;
				free_cls = CLS_W'(c);
				free_rel = OFFSET_W'(64'(free_offset) - BASE_TAB[c]);
			end
		end
		head_sel   = list_head_q[alloc_cls];
		acnt_sel   = 64'd0;
		afirst_sel = 64'd0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (CLS_W'(c) == alloc_cls) begin
				acnt_sel   = COUNT_TAB[c];
				afirst_sel = 64'(c) * 64'(BLOCKS_PER_CLASS);
			end
		end
		head_ok    = (head_sel != '0) && (64'(head_sel) <= acnt_sel);
		alloc_addr = ADDR_W'(afirst_sel) + ADDR_W'(head_sel - LINK_W'(1));
	end

	// per-class constants of the item in flight
	always_comb begin
		bs_s1    = 64'd0;
		base_s1  = 64'd0;
		cnt_s1   = 64'd0;
		first_s1 = 64'd0;
		rcp_s1   = 64'd0;
		sh_s1    = 64'd0;
		clr_cnt  = 64'd0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (CLS_W'(c) == cls_s1) begin
				bs_s1    = BYTES_TAB[c];
				base_s1  = BASE_TAB[c];
				cnt_s1   = COUNT_TAB[c];
				first_s1 = 64'(c) * 64'(BLOCKS_PER_CLASS);
				rcp_s1   = RCP_TAB[c];
				sh_s1    = SHIFT_TAB[c];
			end
			if (CLS_W'(c) == clr_cls_q)
				clr_cnt = COUNT_TAB[c];
		end
		rcp_prod   = PROD_W'(rel_s1) * PROD_W'(rcp_s1);
		div_local  = LOCAL_W'(rcp_prod >> SH_W'(sh_s1));
		chk_prod   = CHK_W'(local_s1) * CHK_W'(bs_s1);
		aligned    = (CMP_W'(chk_prod) == CMP_W'(rel_s1));
		s1_addr    = ADDR_W'(first_s1) + ADDR_W'(local_s1);
		pop_head   = (64'(link_rd_q) <= cnt_s1) ? link_rd_q : '0;
		pop_offset = OFFSET_W'(base_s1) + OFFSET_W'(chk_prod);
		clr_last_local = (64'(clr_local_q) == clr_cnt - 64'd1);
		clr_done       = (clr_addr_q == ADDR_W'(TOTAL_BLOCKS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ALC_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		ld_s1        = 1'b0;
		ld_div       = 1'b0;
		ld_out       = 1'b0;
		mem_re       = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = s1_addr;
		mem_wdata    = list_head_q[cls_s1];
		head_we      = 1'b0;
		head_wdata   = pop_head;
		nx_ok        = 1'b0;
		nx_status    = status_s1;
		nx_offset    = '0;
		nx_class     = CLASS_W'(cls_s1);
		nx_cls_s1    = '0;
		nx_status_s1 = STATUS_OK;
		unique case (state_q)
			ALC_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = LINK_W'(clr_local_q);
				if (clr_done)
					state_d = ALC_IDLE;
			end
			ALC_IDLE: begin
				if (accept) begin
					ld_s1 = 1'b1;
					if (mode == MODE_ALLOC) begin
						if (!alloc_fit) begin
							nx_status_s1 = STATUS_NO_FIT;
							state_d      = ALC_REPLY;
						end else if (!head_ok) begin
							nx_cls_s1    = alloc_cls;
							nx_status_s1 = STATUS_EMPTY;
							state_d      = ALC_REPLY;
						end else begin
							nx_cls_s1 = alloc_cls;
							mem_re    = 1'b1;
							state_d   = ALC_POP;
						end
					end else begin
						if (free_hit) begin
							nx_cls_s1 = free_cls;
							state_d   = ALC_DIV;
						end else begin
							nx_status_s1 = STATUS_BAD_FREE;
							state_d      = ALC_REPLY;
						end
					end
				end
			end
			ALC_POP: begin
				nx_ok     = 1'b1;
				nx_status = STATUS_OK;
				nx_offset = pop_offset;
				if (out_free) begin
					ld_out  = 1'b1;
					head_we = 1'b1;
					state_d = ALC_IDLE;
				end
			end
			ALC_DIV: begin
				ld_div  = 1'b1;
				state_d = ALC_PUSH;
			end
			ALC_PUSH: begin
				head_wdata = LINK_W'(local_s1) + LINK_W'(1);
				if (aligned) begin
					nx_ok     = 1'b1;
					nx_status = STATUS_OK;
				end else begin
					nx_status = STATUS_BAD_FREE;
					nx_class  = '0;
				end
				if (out_free) begin
					ld_out  = 1'b1;
					mem_we  = aligned;
					head_we = aligned;
					state_d = ALC_IDLE;
				end
			end
			ALC_REPLY: begin
				if (out_free) begin
					ld_out  = 1'b1;
					state_d = ALC_IDLE;
				end
			end
			default: state_d = ALC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			clr_cls_q   <= '0;
			clr_local_q <= '0;
		end else if (state_q == ALC_CLEAR && !clr_done) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_last_local) begin
				clr_cls_q   <= clr_cls_q + CLS_W'(1);
				clr_local_q <= '0;
			end else begin
				clr_local_q <= clr_local_q + LOCAL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++)
				list_head_q[c] <= LINK_W'(COUNT_TAB[c]);
		end else if (head_we) begin
			list_head_q[cls_s1] <= head_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			link_mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			link_rd_q <= link_mem[alloc_addr];
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			cls_s1    <= nx_cls_s1;
			status_s1 <= nx_status_s1;
			local_s1  <= LOCAL_W'(head_sel - LINK_W'(1));
			rel_s1    <= free_rel;
		end else if (ld_div) begin
			local_s1 <= div_local;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ld_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			ok_q     <= nx_ok;
			status_q <= nx_status;
			offset_q <= nx_offset;
			class_q  <= nx_class;
		end
	end

endmodule

`default_nettype wire
